FILE: hw/rtl/skvt_pkg.sv
// Package for the sorted key/value table: sizes, operation and status codes,
// and the structs passed along the row of cells. No dependencies.

package skvt_pkg;

   localparam int CAPACITY         = 64;
   localparam int KEY_BITS         = 16;
   localparam int KEY_PORT_BITS    = 16;
   localparam int VALUE_BITS       = 16;
   localparam int COUNT_BITS       = $clog2(CAPACITY + 1);
   localparam int ENTRY_COUNT_BITS = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic      valid;
      key_type   key;
      value_type value;
      logic      after;   // entry sits at or after the insert position
      logic      eq;      // entry key matches the command key
   } link_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic      ins;     // insert into a table that is not full
      logic      rem;     // remove, and some entry matches
      logic      clr;     // drop all entries
      key_type   key;
      value_type value;
      logic      gt0;     // head entry key is greater than the command key
      logic      any_gt;  // some entry key is greater than the command key
   } cmd_type;

endpackage

FILE: hw/rtl/skvt_cell.sv
// One storage cell of the sorted key/value table: holds one entry and takes
// its neighbor's entry on insert or remove. Uses skvt_pkg.

module skvt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               head,
   input  skvt_pkg::cmd_type  cmd,
   input  skvt_pkg::link_type left,
   input  skvt_pkg::link_type right,
   output skvt_pkg::link_type link,
   output logic               gt,
   output skvt_pkg::value_type hit
);

   logic                valid_ff, valid_in;
   skvt_pkg::key_type   key_ff, key_in;
   skvt_pkg::value_type value_ff, value_in;
   logic                ge, eq, after;

   // Compare against the broadcast key
   assign ge    = key_ff >= cmd.key;
   assign eq    = valid_ff && (key_ff == cmd.key);
   assign gt    = valid_ff && (key_ff > cmd.key);
   assign after = valid_ff && (cmd.gt0 || (!head && ge && cmd.any_gt));

   assign link.valid = valid_ff;
   assign link.key   = key_ff;
   assign link.value = value_ff;
   assign link.after = after;
   assign link.eq    = eq;

   // Matches are contiguous: the first one has no matching left neighbor
   assign hit = (eq && !left.eq) ? value_ff : '0;

   // Pick the next entry: hold, empty on clear, shift right on insert, shift left on remove
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      priority if (cmd.clr) begin
         valid_in = 1'b0;
      end else if (cmd.ins) begin
         if (left.after) begin
            valid_in = 1'b1;
            key_in   = left.key;
            value_in = left.value;
         end else if ((after || !valid_ff) && (head || left.valid)) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
            value_in = cmd.value;
         end
      end else if (cmd.rem && valid_ff && ge) begin
         valid_in = right.valid;
         key_in   = right.key;
         value_in = right.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

FILE: hw/rtl/sorted_key_value_table.sv
// Top level of the sorted key/value table: request register, a row of
// skvt_cell instances, fill counter and result register. Uses skvt_pkg.
//
// Usage:
//   A request word (req_operation, req_key, req_value) is taken at a rising
//   edge where start is high and busy is low. Operations: insert, find,
//   remove first match, clear.
//   The result word (rsp_status, rsp_found_value, rsp_entry_count) shows for
//   exactly one cycle with rsp_valid high, once it has passed the request
//   register and the result register. Throughput is one request per cycle
//   while busy is low: every cell compares its entry with the request key in
//   parallel and shifts toward its neighbor in the same cycle, so the request
//   register and the result register are the only registers around the cell row.
//   Entries are kept in ascending key order; a new key goes ahead of entries
//   with an equal key, except that a key equal to the last entry goes to the
//   end and one equal to the head entry otherwise lands right after the head.
//   Reset (synchronous) empties the table, drops any request in flight and
//   holds busy high during reset and in the cycle after it. The receiver
//   cannot stall: a result is taken in the cycle it is shown.

module sorted_key_value_table (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_operation,
   input  logic [skvt_pkg::KEY_PORT_BITS-1:0]     req_key,
   input  logic [skvt_pkg::VALUE_BITS-1:0]        req_value,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic [skvt_pkg::VALUE_BITS-1:0]        rsp_found_value,
   output logic [skvt_pkg::ENTRY_COUNT_BITS-1:0]  rsp_entry_count
);

   logic                busy_ff;
   logic                req_valid_ff;
   skvt_pkg::op_type    req_op_ff;
   skvt_pkg::key_type   req_key_ff;
   skvt_pkg::value_type req_value_ff;

   skvt_pkg::count_type count_ff, count_in;

   logic                rsp_valid_ff;
   skvt_pkg::status_type rsp_status_ff, rsp_status_in;
   skvt_pkg::value_type rsp_found_ff, rsp_found_in;
   logic [skvt_pkg::ENTRY_COUNT_BITS-1:0] rsp_count_ff;

   skvt_pkg::link_type  links [skvt_pkg::CAPACITY];
   logic [skvt_pkg::CAPACITY-1:0] gt_vec;
   logic [skvt_pkg::CAPACITY-1:0] eq_vec;
   skvt_pkg::value_type hits [skvt_pkg::CAPACITY];
   skvt_pkg::value_type hit_any;
   skvt_pkg::cmd_type   cmd;
   logic                full, any_eq, accept;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Register the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_op_ff    <= skvt_pkg::op_type'(req_operation);
         req_key_ff   <= req_key[skvt_pkg::KEY_BITS-1:0];
         req_value_ff <= req_value;
      end
   end

   // Collect match flags and the first matching value from the row
   always_comb begin
      hit_any = '0;
      for (int i = 0; i < skvt_pkg::CAPACITY; i++) begin
         eq_vec[i] = links[i].eq;
         hit_any   = hit_any | hits[i];
      end
   end

   assign any_eq = |eq_vec;
   assign full   = count_ff == skvt_pkg::COUNT_BITS'(skvt_pkg::CAPACITY);

   // Build the broadcast command
   assign cmd.ins    = req_valid_ff && (req_op_ff == skvt_pkg::OP_INSERT) && !full;
   assign cmd.rem    = req_valid_ff && (req_op_ff == skvt_pkg::OP_REMOVE) && any_eq;
   assign cmd.clr    = req_valid_ff && (req_op_ff == skvt_pkg::OP_CLEAR);
   assign cmd.key    = req_key_ff;
   assign cmd.value  = req_value_ff;
   assign cmd.gt0    = gt_vec[0];
   assign cmd.any_gt = |gt_vec;

   // Row of cells, head at index zero
   for (genvar g = 0; g < skvt_pkg::CAPACITY; g++) begin : g_cell
      skvt_pkg::link_type left_link, right_link;
      if (g == 0) begin : g_head
         assign left_link = '0;
      end else begin : g_body
         assign left_link = links[g-1];
      end
      if (g == skvt_pkg::CAPACITY - 1) begin : g_tail
         assign right_link = '0;
      end else begin : g_inner
         assign right_link = links[g+1];
      end
      skvt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .head  (g == 0),
         .cmd   (cmd),
         .left  (left_link),
         .right (right_link),
         .link  (links[g]),
         .gt    (gt_vec[g]),
         .hit   (hits[g])
      );
   end

   // Work out count and result
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = skvt_pkg::ST_DONE;
      rsp_found_in  = '0;
      unique case (req_op_ff)
         skvt_pkg::OP_INSERT: begin
            if (full) begin
               rsp_status_in = skvt_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         skvt_pkg::OP_FIND: begin
            if (any_eq) begin
               rsp_found_in = hit_any;
            end else begin
               rsp_status_in = skvt_pkg::ST_MISSING;
            end
         end
         skvt_pkg::OP_REMOVE: begin
            if (any_eq) begin
               count_in = count_ff - 1'b1;
            end else begin
               rsp_status_in = skvt_pkg::ST_MISSING;
            end
         end
         skvt_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Advance count and result on a live request
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= skvt_pkg::ENTRY_COUNT_BITS'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: hw/rtl/skvt_checker.sv
// Port-level checks for the sorted key/value table, bound to its top level.
// Uses skvt_pkg.

module skvt_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic [1:0]                             rsp_status,
   input logic [skvt_pkg::VALUE_BITS-1:0]        rsp_found_value,
   input logic [skvt_pkg::ENTRY_COUNT_BITS-1:0]  rsp_entry_count
);

   // Every accepted word gives a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result missing after accepted request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without request");

   // Found value only on success
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != skvt_pkg::ST_DONE) |-> rsp_found_value == '0)
      else $error("found value on failed operation");

   // Full status only with a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == skvt_pkg::ST_FULL) |->
         rsp_entry_count == skvt_pkg::ENTRY_COUNT_BITS'(skvt_pkg::CAPACITY))
      else $error("full status with room left");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (.*);
